@@ rtl/core/ptb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes for the periodic timer bank: command and result
// codes, transfer payloads and the control bundle from the slot evaluator.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int ID_WIDTH_DEF   = 16;

  // command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_DESTROY = 3'd2;
  localparam logic [2:0] CMD_START   = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;
  localparam logic [2:0] CMD_SET_PER = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;
  localparam logic [2:0] CMD_NOP     = 3'd7;

  // result kinds
  localparam logic [2:0] KIND_FIRED   = 3'd0;
  localparam logic [2:0] KIND_CREATED = 3'd1;
  localparam logic [2:0] KIND_ACK     = 3'd2;
  localparam logic [2:0] KIND_RUNNING = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;
  localparam logic [2:0] KIND_FULL    = 3'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_time;
    logic [15:0] timer_id;
    logic [31:0] period;
    logic [15:0] user_tag;
  } ptb_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic [15:0] result_tag;
    logic        is_running;
    logic        last_of_run;
  } ptb_out_t;

  typedef struct packed {
    logic hit;        // this slot is the one acted on
    logic wr_en;      // write back the slot entry
    logic set_valid;
    logic clr_valid;
  } ptb_ctl_t;

endpackage

@@ rtl/core/ptb_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_slot_mem
// Slot entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptb_slot_mem
  import ptb_pkg::*;
#(
  parameter int DEPTH  = NUM_TIMERS_DEF,
  parameter int ADDR_W = 4,
  parameter int DATA_W = ID_WIDTH_DEF + 81
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] slot_mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

endmodule

@@ rtl/core/ptb_slot_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_slot_eval
// Shared per-slot unit: elapsed-time subtract and compare, id compare, and
// the updated entry and result for the slot under the scan.
// ----------------------------------------------------------------------------
module ptb_slot_eval
  import ptb_pkg::*;
#(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  ptb_in_t              cmd,
  input  logic [ID_WIDTH-1:0]  next_ident,
  input  logic                 slot_vld,
  input  logic [ID_WIDTH-1:0]  ent_ident,
  input  logic [15:0]          ent_tag,
  input  logic [31:0]          ent_period,
  input  logic [31:0]          ent_last,
  input  logic                 ent_running,
  output ptb_ctl_t             ctl,
  output ptb_out_t             res,
  output logic [ID_WIDTH-1:0]  wr_ident,
  output logic [15:0]          wr_tag,
  output logic [31:0]          wr_period,
  output logic [31:0]          wr_last,
  output logic                 wr_running
);

  localparam int CMP_W = (ID_WIDTH > 16) ? ID_WIDTH : 16;

  logic [31:0] elapsed;
  logic        due;
  logic        id_match;

  assign elapsed  = cmd.now_time - ent_last;   // wraps like the time base
  assign due      = elapsed >= ent_period;
  assign id_match = CMP_W'(ent_ident) == CMP_W'(cmd.timer_id);

  always_comb begin
    ctl             = '0;
    wr_ident        = ent_ident;
    wr_tag          = ent_tag;
    wr_period       = ent_period;
    wr_last         = ent_last;
    wr_running      = ent_running;
    res.kind        = KIND_ACK;
    res.result_id   = cmd.timer_id;
    res.result_tag  = '0;
    res.is_running  = 1'b0;
    res.last_of_run = 1'b1;
    case (cmd.command)
      CMD_TICK: begin
        ctl.hit         = slot_vld && ent_running && due;
        ctl.wr_en       = 1'b1;
        wr_last         = cmd.now_time;
        res.kind        = KIND_FIRED;
        res.result_id   = 16'(ent_ident);
        res.result_tag  = ent_tag;
        res.last_of_run = 1'b0;
      end
      CMD_CREATE: begin
        ctl.hit       = !slot_vld;
        ctl.wr_en     = 1'b1;
        ctl.set_valid = 1'b1;
        wr_ident      = next_ident;
        wr_tag        = cmd.user_tag;
        wr_period     = cmd.period;
        wr_last       = '0;
        wr_running    = 1'b1;
        res.kind      = KIND_CREATED;
        res.result_id = 16'(next_ident);
      end
      CMD_DESTROY: begin
        ctl.hit       = slot_vld && id_match;
        ctl.clr_valid = 1'b1;
      end
      CMD_START: begin
        ctl.hit    = slot_vld && id_match;
        ctl.wr_en  = 1'b1;
        wr_running = 1'b1;
      end
      CMD_STOP: begin
        ctl.hit    = slot_vld && id_match;
        ctl.wr_en  = 1'b1;
        wr_running = 1'b0;
      end
      CMD_SET_PER: begin
        ctl.hit   = slot_vld && id_match;
        ctl.wr_en = 1'b1;
        wr_period = cmd.period;
      end
      CMD_QUERY: begin
        ctl.hit        = slot_vld && id_match;
        res.kind       = KIND_RUNNING;
        res.is_running = ent_running;
      end
      default: begin
        ctl.hit = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/periodic_timer_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank
// A command is registered, the slots are read in order from slot 0, each read
// entry is evaluated and its result is written to the output register. A create
// or lookup stops at the slot it hits; a tick or a miss scans all slots. One
// command at a time: in_stall is high until it is done; output stalls hold the
// scan. Sync active-low reset clears all slots and the id counter; slot memory
// contents are don't-care until created.
// ----------------------------------------------------------------------------
module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ptb_out_t out_data
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ENT_W = ID_WIDTH + 16 + 32 + 32 + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                st_r, st_nxt;
  ptb_in_t               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  issue_r, issue_nxt;
  logic [IDX_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic                  hold_vld_r, hold_vld_nxt;
  ptb_out_t              hold_data_r, hold_data_nxt;
  logic                  out_vld_r, out_vld_nxt;
  ptb_out_t              out_data_r, out_data_nxt;
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [ID_WIDTH-1:0]   next_ident_r, next_ident_nxt;

  logic                  mem_rd_en;
  logic                  mem_wr_en;
  logic [ENT_W-1:0]      mem_rd_data;
  logic [ENT_W-1:0]      mem_wr_data;

  ptb_ctl_t              ctl;
  ptb_out_t              ev_res;
  logic [ID_WIDTH-1:0]   wr_ident;
  logic [15:0]           wr_tag;
  logic [31:0]           wr_period;
  logic [31:0]           wr_last;
  logic                  wr_running;

  logic                  out_free;
  logic                  is_tick;
  logic                  push;
  ptb_out_t              push_data;
  logic                  advance;
  logic                  done;

  ptb_slot_mem #(
    .DEPTH  (NUM_TIMERS),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (ev_idx_r),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (rd_idx_r),
    .rd_data_r (mem_rd_data)
  );

  ptb_slot_eval #(
    .ID_WIDTH (ID_WIDTH)
  ) u_eval (
    .cmd         (cmd_r),
    .next_ident  (next_ident_r),
    .slot_vld    (valid_r[ev_idx_r]),
    .ent_ident   (mem_rd_data[ENT_W-1 -: ID_WIDTH]),
    .ent_tag     (mem_rd_data[80:65]),
    .ent_period  (mem_rd_data[64:33]),
    .ent_last    (mem_rd_data[32:1]),
    .ent_running (mem_rd_data[0]),
    .ctl         (ctl),
    .res         (ev_res),
    .wr_ident    (wr_ident),
    .wr_tag      (wr_tag),
    .wr_period   (wr_period),
    .wr_last     (wr_last),
    .wr_running  (wr_running)
  );

  assign mem_wr_data = {wr_ident, wr_tag, wr_period, wr_last, wr_running};

  assign out_free  = !out_vld_r || !out_stall;
  assign is_tick   = cmd_r.command == CMD_TICK;
  assign in_stall  = st_r != ST_IDLE;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt         = st_r;
    cmd_nxt        = cmd_r;
    rd_idx_nxt     = rd_idx_r;
    issue_nxt      = issue_r;
    ev_idx_nxt     = ev_idx_r;
    ev_vld_nxt     = ev_vld_r;
    hold_vld_nxt   = hold_vld_r;
    hold_data_nxt  = hold_data_r;
    valid_nxt      = valid_r;
    next_ident_nxt = next_ident_r;
    mem_rd_en      = 1'b0;
    mem_wr_en      = 1'b0;
    push           = 1'b0;
    push_data      = '0;
    advance        = 1'b1;
    done           = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          if (in_data.command != CMD_NOP) begin
            st_nxt       = ST_SCAN;
            rd_idx_nxt   = '0;
            issue_nxt    = 1'b1;
            ev_vld_nxt   = 1'b0;
            hold_vld_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (ev_vld_r && ctl.hit) begin
          if (is_tick) begin
            // the held firing goes out once a later one shows it is not last
            if (hold_vld_r && !out_free) begin
              advance = 1'b0;
            end else begin
              push          = hold_vld_r;
              push_data     = hold_data_r;
              hold_vld_nxt  = 1'b1;
              hold_data_nxt = ev_res;
              mem_wr_en     = 1'b1;
            end
          end else if (!out_free) begin
            advance = 1'b0;
          end else begin
            push      = 1'b1;
            push_data = ev_res;
            mem_wr_en = ctl.wr_en;
            if (ctl.set_valid) begin
              valid_nxt[ev_idx_r] = 1'b1;
              next_ident_nxt      = next_ident_r + 1'b1;
            end
            if (ctl.clr_valid) begin
              valid_nxt[ev_idx_r] = 1'b0;
            end
            done       = 1'b1;
            st_nxt     = ST_IDLE;
            issue_nxt  = 1'b0;
            ev_vld_nxt = 1'b0;
          end
        end
        if (advance && !done) begin
          if (issue_r) begin
            mem_rd_en  = 1'b1;
            ev_idx_nxt = rd_idx_r;
            ev_vld_nxt = 1'b1;
            rd_idx_nxt = rd_idx_r + 1'b1;
            issue_nxt  = rd_idx_r != LAST_IDX;
          end else begin
            ev_vld_nxt = 1'b0;
            if (!ev_vld_r) begin
              st_nxt = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        if (is_tick) begin
          if (!hold_vld_r) begin
            st_nxt = ST_IDLE;
          end else if (out_free) begin
            push                  = 1'b1;
            push_data             = hold_data_r;
            push_data.last_of_run = 1'b1;
            hold_vld_nxt          = 1'b0;
            st_nxt                = ST_IDLE;
          end
        end else if (out_free) begin
          push                  = 1'b1;
          push_data.last_of_run = 1'b1;
          if (cmd_r.command == CMD_CREATE) begin
            push_data.kind = KIND_FULL;
          end else begin
            push_data.kind      = KIND_UNKNOWN;
            push_data.result_id = cmd_r.timer_id;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = push_data;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      issue_r      <= 1'b0;
      ev_vld_r     <= 1'b0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      valid_r      <= '0;
      next_ident_r <= '0;
      rd_idx_r     <= '0;
    end else begin
      st_r         <= st_nxt;
      issue_r      <= issue_nxt;
      ev_vld_r     <= ev_vld_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      valid_r      <= valid_nxt;
      next_ident_r <= next_ident_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ev_idx_r    <= ev_idx_nxt;
    hold_data_r <= hold_data_nxt;
    out_data_r  <= out_data_nxt;
  end

  // single-result commands always close their run
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_FIRED) |-> out_data.last_of_run)
    else $error("non-fired result without last marker");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> (st_r == ST_SCAN))
    else $error("slot evaluation outside scan");

  a_hold_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (cmd_r.command == CMD_TICK))
    else $error("held firing on a non-tick command");

  a_ident_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) && ev_vld_r && ctl.hit && (cmd_r.command == CMD_CREATE) && out_free
    |=> next_ident_r == ID_WIDTH'($past(next_ident_r) + 1'b1))
    else $error("id counter did not advance on create");

  a_one_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r & ~$past(valid_r)) <= 1)
    else $error("more than one slot allocated in a cycle");

endmodule

@@ sim/periodic_timer_bank_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_tb
// Self-checking bench for the periodic timer bank. Directed command sequences
// (firing, zero/max periods, time wrap, slot commands, unknown ids, full
// table, slot reuse) and random command traffic are sent; a local model
// of the timer table predicts every result and a monitor checks each output
// transfer in order, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module periodic_timer_bank_tb;
  import ptb_pkg::*;

  localparam int NT          = NUM_TIMERS_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RAND_ITEMS  = 190;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ptb_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ptb_out_t out_data;

  // timer table as the bench sees it
  logic        tm_valid   [NT];
  logic [15:0] tm_ident   [NT];
  logic [15:0] tm_tag     [NT];
  logic [31:0] tm_period  [NT];
  logic [31:0] tm_last    [NT];
  logic        tm_running [NT];
  logic [15:0] tm_next_id = '0;

  ptb_out_t    pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;
  logic [31:0] tick_time   = '0;

  periodic_timer_bank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && idle_on && ($urandom_range(99) < 14);
  end

  // ---- table model --------------------------------------------------------

  function automatic void push_result(input logic [2:0] kind, input logic [15:0] id,
                                      input logic [15:0] tag, input logic run,
                                      input logic last);
    ptb_out_t r;
    r.kind        = kind;
    r.result_id   = id;
    r.result_tag  = tag;
    r.is_running  = run;
    r.last_of_run = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_command(input ptb_in_t c);
    int       slot;
    int       fired;
    ptb_out_t r;
    slot  = -1;
    fired = 0;
    case (c.command)
      CMD_TICK: begin
        for (int s = 0; s < NT; s++) begin
          if (tm_valid[s] && tm_running[s] &&
              (32'(c.now_time - tm_last[s]) >= tm_period[s])) begin
            tm_last[s] = c.now_time;
            push_result(KIND_FIRED, tm_ident[s], tm_tag[s], 1'b0, 1'b0);
            fired++;
          end
        end
        if (fired > 0) begin
          r = pending_results.pop_back();
          r.last_of_run = 1'b1;
          pending_results.push_back(r);
        end
      end
      CMD_CREATE: begin
        for (int s = NT - 1; s >= 0; s--)
          if (!tm_valid[s]) slot = s;
        if (slot < 0) begin
          push_result(KIND_FULL, 16'd0, 16'd0, 1'b0, 1'b1);
        end else begin
          tm_valid[slot]   = 1'b1;
          tm_ident[slot]   = tm_next_id;
          tm_tag[slot]     = c.user_tag;
          tm_period[slot]  = c.period;
          tm_last[slot]    = '0;
          tm_running[slot] = 1'b1;
          tm_next_id       = tm_next_id + 16'd1;
          push_result(KIND_CREATED, tm_ident[slot], 16'd0, 1'b0, 1'b1);
        end
      end
      CMD_NOP: ;
      default: begin
        for (int s = NT - 1; s >= 0; s--)
          if (tm_valid[s] && tm_ident[s] == c.timer_id) slot = s;
        if (slot < 0) begin
          push_result(KIND_UNKNOWN, c.timer_id, 16'd0, 1'b0, 1'b1);
        end else if (c.command == CMD_QUERY) begin
          push_result(KIND_RUNNING, c.timer_id, 16'd0, tm_running[slot], 1'b1);
        end else begin
          case (c.command)
            CMD_DESTROY: tm_valid[slot]   = 1'b0;
            CMD_START:   tm_running[slot] = 1'b1;
            CMD_STOP:    tm_running[slot] = 1'b0;
            default:     tm_period[slot]  = c.period;
          endcase
          push_result(KIND_ACK, c.timer_id, 16'd0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic logic [15:0] target_id();
    int live;
    int pick;
    live = 0;
    for (int s = 0; s < NT; s++)
      if (tm_valid[s]) live++;
    if (live == 0 || $urandom_range(99) < 15) return 16'($urandom);
    pick = $urandom_range(live - 1);
    for (int s = 0; s < NT; s++) begin
      if (tm_valid[s]) begin
        if (pick == 0) return tm_ident[s];
        pick--;
      end
    end
    return 16'($urandom);
  endfunction

  // ---- input side ---------------------------------------------------------

  task automatic send(input logic [2:0] cmd, input logic [31:0] now_t,
                      input logic [15:0] id, input logic [31:0] per,
                      input logic [15:0] tag);
    ptb_in_t item;
    item.command  = cmd;
    item.now_time = now_t;
    item.timer_id = id;
    item.period   = per;
    item.user_tag = tag;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(item);
  endtask

  // ---- output side --------------------------------------------------------

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    ptb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 40)
          $display("%0t: unexpected transfer, expected none, actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        compare_field("kind",        32'(want.kind),        32'(out_data.kind));
        compare_field("result_id",   32'(want.result_id),   32'(out_data.result_id));
        compare_field("result_tag",  32'(want.result_tag),  32'(out_data.result_tag));
        compare_field("is_running",  32'(want.is_running),  32'(out_data.is_running));
        compare_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  // ---- tests --------------------------------------------------------------

  task automatic test_firing;
    send(CMD_TICK,   32'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);   // empty table: quiet
    send(CMD_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'hFFFF);   // fires every tick
    send(CMD_CREATE, 32'd0, 16'd0, 32'hFFFF_FFFF, 16'h0000);
    send(CMD_CREATE, 32'd0, 16'd0, 32'd10, 16'hA5A5);
    send(CMD_TICK,   32'd0, 16'd0, 32'd0, 16'd0);
    send(CMD_TICK,   32'd10, 16'd0, 32'd0, 16'd0);
    send(CMD_TICK,   32'hFFFF_FFFF, 16'd0, 32'd0, 16'd0);         // max period reached
    send(CMD_TICK,   32'd5, 16'd0, 32'd0, 16'd0);                 // time wrapped
  endtask

  task automatic test_slot_commands;
    send(CMD_QUERY,   32'd0, 16'd2, 32'd0, 16'd0);
    send(CMD_STOP,    32'd0, 16'd2, 32'd0, 16'd0);
    send(CMD_QUERY,   32'd0, 16'd2, 32'd0, 16'd0);
    send(CMD_TICK,    32'd100, 16'd0, 32'd0, 16'd0);
    send(CMD_START,   32'd0, 16'd2, 32'd0, 16'd0);
    send(CMD_SET_PER, 32'd0, 16'd2, 32'd0, 16'd0);
    send(CMD_TICK,    32'd100, 16'd0, 32'd0, 16'd0);
    send(CMD_DESTROY, 32'd0, 16'd1, 32'd0, 16'd0);
    send(CMD_QUERY,   32'd0, 16'd1, 32'd0, 16'd0);
    send(CMD_DESTROY, 32'd0, 16'hFFFF, 32'd0, 16'd0);
    send(CMD_START,   32'd0, 16'h8000, 32'd0, 16'd0);
    send(CMD_STOP,    32'd0, 16'h7FFF, 32'd0, 16'd0);
    send(CMD_SET_PER, 32'd0, 16'h0100, 32'hFFFF_FFFF, 16'd0);
    send(CMD_NOP,     32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(CMD_CREATE,  32'd0, 16'd0, 32'd7, 16'h5A5A);            // reuses the freed slot
    tick_time = 32'd100;
  endtask

  task automatic test_table_full;
    int live;
    do begin
      live = 0;
      for (int s = 0; s < NT; s++)
        if (tm_valid[s]) live++;
      if (live < NT)
        send(CMD_CREATE, $urandom, 16'($urandom), $urandom_range(0, 20), 16'($urandom));
    end while (live < NT);
    send(CMD_CREATE, $urandom, 16'($urandom), $urandom, 16'($urandom));
    send(CMD_CREATE, $urandom, 16'($urandom), $urandom, 16'($urandom));
    tick_time = tick_time + 32'd40;
    send(CMD_TICK, tick_time, 16'($urandom), $urandom, 16'($urandom));   // whole table fires
    repeat (4) send(CMD_DESTROY, $urandom, target_id(), $urandom, 16'($urandom));
  endtask

  task automatic test_random_traffic;
    int          sent;
    int          r;
    logic [31:0] per;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      idle_on = !(sent >= 100 && sent < 160);
      r   = $urandom_range(99);
      per = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 60));
      sent++;
      if (r < 35) begin
        case ($urandom_range(19))
          0:       tick_time = $urandom;
          1:       tick_time = 32'hFFFF_FFFF - $urandom_range(0, 30);
          default: tick_time = tick_time + $urandom_range(0, 40);
        endcase
        send(CMD_TICK, tick_time, 16'($urandom), $urandom, 16'($urandom));
      end else if (r < 50) begin
        send(CMD_CREATE, $urandom, 16'($urandom), per, 16'($urandom));
      end else if (r < 60) begin
        send(CMD_DESTROY, $urandom, target_id(), $urandom, 16'($urandom));
      end else if (r < 68) begin
        send(CMD_START, $urandom, target_id(), $urandom, 16'($urandom));
      end else if (r < 76) begin
        send(CMD_STOP, $urandom, target_id(), $urandom, 16'($urandom));
      end else if (r < 84) begin
        send(CMD_SET_PER, $urandom, target_id(), per, 16'($urandom));
      end else if (r < 94) begin
        send(CMD_QUERY, $urandom, target_id(), $urandom, 16'($urandom));
      end else if (r < 97) begin
        sent--;   // ignored by the block
        send(CMD_NOP, $urandom, 16'($urandom), $urandom, 16'($urandom));
      end else begin
        send(3'($urandom_range(CMD_DESTROY, CMD_QUERY)), $urandom, 16'($urandom),
             $urandom, 16'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  // Empty the table, then free the lowest slot so a new timer lands ahead of
  // an older one, and address the older timer by id.
  task automatic test_slot_reuse;
    logic [15:0] keep_id;
    idle_on = 1'b0;
    for (int s = 0; s < NT; s++)
      if (tm_valid[s]) send(CMD_DESTROY, $urandom, tm_ident[s], $urandom, 16'($urandom));
    send(CMD_CREATE, 32'd0, 16'd0, 32'd3, 16'h1111);
    keep_id = tm_next_id;
    send(CMD_CREATE, 32'd0, 16'd0, 32'd3, 16'h2222);
    send(CMD_DESTROY, 32'd0, tm_ident[0], 32'd0, 16'd0);
    send(CMD_CREATE, 32'd0, 16'd0, 32'd3, 16'h3333);
    idle_on = 1'b1;
    send(CMD_QUERY,   32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_STOP,    32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_QUERY,   32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_TICK,    32'd100, 16'd0, 32'd0, 16'd0);
    send(CMD_SET_PER, 32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_DESTROY, 32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_QUERY,   32'd0, keep_id, 32'd0, 16'd0);
    send(CMD_TICK,    32'd101, 16'd0, 32'd0, 16'd0);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NT + 8) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < NT; s++) begin
      tm_valid[s]   = 1'b0;
      tm_ident[s]   = '0;
      tm_tag[s]     = '0;
      tm_period[s]  = '0;
      tm_last[s]    = '0;
      tm_running[s] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_firing();
    test_slot_commands();
    test_table_full();
    test_random_traffic();
    test_slot_reuse();
    drain();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ptb_pkg.sv
rtl/core/ptb_slot_mem.sv
rtl/core/ptb_slot_eval.sv
rtl/core/periodic_timer_bank.sv
sim/periodic_timer_bank_tb.sv
